FILE: rtl/bhf_pkg.sv
// Shared types and constants for the binned histogram fill block.
// Used by bhf_div, bhf_bin_store and binned_histogram_fill; no dependencies.
package bhf_pkg;

  // Fixed field widths of the item and result channels
  localparam int SAMPLE_W  = 16;
  localparam int SEL_W     = 8;
  localparam int STATUS_W  = 3;
  localparam int IDX_OUT_W = 8;
  localparam int CNT_OUT_W = 32;
  localparam int SUM_W     = 48;
  localparam int SQSUM_W   = 63;
  localparam int SQ_W      = 31;
  localparam int OFF_W     = 16;
  localparam int BC_CFG_W  = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_BINNED    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_READ_OK   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_READ_BAD  = 3'd4;

  // Operation codes
  localparam logic OP_FILL = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_EDGE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_EDGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT = 2'd2;

  // Control state machine
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_READ,
    ST_UPD,
    ST_OUT
  } bhf_state_t;

  // Requests from the controller to the bin store
  typedef struct packed {
    logic rd_en;
    logic inc_en;
  } bhf_store_ctrl_t;

endpackage

FILE: rtl/binned_histogram_fill.sv
// Uniform-bin histogram: an item is accepted, classified, divided to a bin number,
// then its bin counter is read, incremented and written back; the result holds in an output register.
// A fill runs EVAL, DIV, READ, UPD and OUT; a bin read skips DIV; underflow, overflow and a bad
// read go from EVAL straight to OUT. One item in flight: the next item is accepted only after OUT
// loads the output register. The divider in DIV yields one quotient bit per cycle.
// Reset (rst_n low, synchronous) clears all totals, then a sweep over all MAX_BINS bins zeroes them.
module binned_histogram_fill #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [bhf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bhf_pkg::CFG_W-1:0]         cfg_data,
  // item input
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [23:0]                       in_tdata,  // [15:0] sample, [23:16] bin_select
  input  logic                              in_tuser,  // [0] op
  // result output
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [247:0]                      out_tdata, // [7:0] bin_index, [39:8] bin_value,
                                                       // [71:40] entries, [103:72] underflow_count,
                                                       // [135:104] overflow_count,
                                                       // [183:136] value_sum, [246:184] square_sum,
                                                       // [247] zero
  output logic [bhf_pkg::STATUS_W-1:0]      out_tuser  // [2:0] status
);

  localparam int QW    = $clog2(MAX_BINS);       // bin number width
  localparam int BC_W  = $clog2(MAX_BINS + 1);   // bins-in-use width
  localparam int DVD_W = bhf_pkg::OFF_W + BC_W;  // offset times bins

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [bhf_pkg::SAMPLE_W-1:0] low_edge_r;
  logic signed [bhf_pkg::SAMPLE_W-1:0] high_edge_r;
  logic [bhf_pkg::BC_CFG_W-1:0]        bin_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_edge_r  <= 16'sh8000;
      high_edge_r <= 16'sh7FFF;
      bin_count_r <= 9'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        bhf_pkg::REG_LOW_EDGE:  low_edge_r  <= cfg_data;
        bhf_pkg::REG_HIGH_EDGE: high_edge_r <= cfg_data;
        bhf_pkg::REG_BIN_COUNT: bin_count_r <= cfg_data[bhf_pkg::BC_CFG_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Bins in use: zero acts as one, anything above MAX_BINS acts as MAX_BINS
  logic [BC_W-1:0] bins_used;

  always_comb begin
    if (bin_count_r == '0) begin
      bins_used = BC_W'(1);
    end else if (32'(bin_count_r) > MAX_BINS) begin
      bins_used = BC_W'(MAX_BINS);
    end else begin
      bins_used = BC_W'(bin_count_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Item registers and state
  // ---------------------------------------------------------------------------
  bhf_pkg::bhf_state_t state_r, state_nxt;

  logic                                op_r;
  logic signed [bhf_pkg::SAMPLE_W-1:0] sample_r;
  logic [bhf_pkg::SEL_W-1:0]           sel_r;
  logic [QW-1:0]                       addr_r;
  logic [bhf_pkg::SQ_W-1:0]            sq_r;
  logic [bhf_pkg::STATUS_W-1:0]        status_r;
  logic [bhf_pkg::IDX_OUT_W-1:0]       idx_r;
  logic [COUNT_BITS-1:0]               val_r;

  // Running totals
  logic [COUNT_BITS-1:0]               entry_r;
  logic [COUNT_BITS-1:0]               below_r;
  logic [COUNT_BITS-1:0]               above_r;
  logic signed [bhf_pkg::SUM_W-1:0]    sum_r;
  logic [bhf_pkg::SQSUM_W-1:0]         sqsum_r;

  // Output register
  logic                                out_valid_r;
  logic [bhf_pkg::STATUS_W-1:0]        out_status_r;
  logic [bhf_pkg::IDX_OUT_W-1:0]       out_idx_r;
  logic [bhf_pkg::CNT_OUT_W-1:0]       out_val_r;
  logic [bhf_pkg::CNT_OUT_W-1:0]       out_entries_r;
  logic [bhf_pkg::CNT_OUT_W-1:0]       out_under_r;
  logic [bhf_pkg::CNT_OUT_W-1:0]       out_over_r;
  logic [bhf_pkg::SUM_W-1:0]           out_sum_r;
  logic [bhf_pkg::SQSUM_W-1:0]         out_sqsum_r;

  // ---------------------------------------------------------------------------
  // Classification of the held item
  // ---------------------------------------------------------------------------
  logic                                is_under;
  logic                                is_over;
  logic                                sel_ok;
  logic signed [bhf_pkg::SAMPLE_W:0]   off_wide;
  logic signed [bhf_pkg::SAMPLE_W:0]   span_wide;
  logic [bhf_pkg::OFF_W-1:0]           off;
  logic [bhf_pkg::OFF_W-1:0]           span;
  logic [DVD_W-1:0]                    dividend;
  logic signed [31:0]                  sq_full;

  // An empty range puts every sample at or above low_edge into overflow
  assign is_under  = (sample_r < low_edge_r);
  assign is_over   = !is_under && (sample_r >= high_edge_r);
  assign sel_ok    = (32'(sel_r) < 32'(bins_used));
  // Offset is non-negative, span is positive, and both are below 2^16 whenever the sample is binned
  assign off_wide  = (bhf_pkg::SAMPLE_W+1)'(sample_r) - (bhf_pkg::SAMPLE_W+1)'(low_edge_r);
  assign span_wide = (bhf_pkg::SAMPLE_W+1)'(high_edge_r) - (bhf_pkg::SAMPLE_W+1)'(low_edge_r);
  assign off       = off_wide[bhf_pkg::OFF_W-1:0];
  assign span      = span_wide[bhf_pkg::OFF_W-1:0];
  assign dividend  = DVD_W'(off) * DVD_W'(bins_used);
  assign sq_full   = sample_r * sample_r;

  // ---------------------------------------------------------------------------
  // Divider and bin store
  // ---------------------------------------------------------------------------
  logic                     div_start;
  logic                     div_busy;
  logic [QW-1:0]            quotient;
  bhf_pkg::bhf_store_ctrl_t store_ctrl;
  logic                     store_clearing;
  logic [COUNT_BITS-1:0]    rd_count;
  logic [COUNT_BITS-1:0]    inc_count;
  logic                     in_accept;
  logic                     out_load;

  bhf_div #(
    .DVD_W (DVD_W),
    .QW    (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span),
    .busy     (div_busy),
    .quotient (quotient)
  );

  bhf_bin_store #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (store_ctrl),
    .addr      (addr_r),
    .clearing  (store_clearing),
    .rd_count  (rd_count),
    .inc_count (inc_count)
  );

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bhf_pkg::ST_CLEAR: begin
        if (!store_clearing) state_nxt = bhf_pkg::ST_IDLE;
      end
      bhf_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = bhf_pkg::ST_EVAL;
      end
      bhf_pkg::ST_EVAL: begin
        if (op_r == bhf_pkg::OP_READ) begin
          state_nxt = sel_ok ? bhf_pkg::ST_READ : bhf_pkg::ST_OUT;
        end else if (is_under || is_over) begin
          state_nxt = bhf_pkg::ST_OUT;
        end else begin
          state_nxt = bhf_pkg::ST_DIV;
        end
      end
      bhf_pkg::ST_DIV: begin
        if (!div_busy) state_nxt = bhf_pkg::ST_READ;
      end
      bhf_pkg::ST_READ: state_nxt = bhf_pkg::ST_UPD;
      bhf_pkg::ST_UPD:  state_nxt = bhf_pkg::ST_OUT;
      bhf_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = bhf_pkg::ST_IDLE;
      end
      default: state_nxt = bhf_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bhf_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // State outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_tready         = 1'b0;
    div_start         = 1'b0;
    store_ctrl.rd_en  = 1'b0;
    store_ctrl.inc_en = 1'b0;
    out_load          = 1'b0;
    case (state_r)
      bhf_pkg::ST_IDLE: in_tready = 1'b1;
      bhf_pkg::ST_EVAL: div_start = (op_r == bhf_pkg::OP_FILL) && !is_under && !is_over;
      bhf_pkg::ST_READ: store_ctrl.rd_en = 1'b1;
      bhf_pkg::ST_UPD:  store_ctrl.inc_en = (op_r == bhf_pkg::OP_FILL);
      bhf_pkg::ST_OUT:  out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign in_accept = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Item datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= in_tuser;
      sample_r <= in_tdata[15:0];
      sel_r    <= in_tdata[23:16];
    end
    case (state_r)
      bhf_pkg::ST_EVAL: begin
        // Defaults for results that carry no bin
        status_r <= bhf_pkg::STAT_READ_BAD;
        idx_r    <= '0;
        val_r    <= '0;
        addr_r   <= QW'(sel_r);
        sq_r     <= sq_full[bhf_pkg::SQ_W-1:0];
        if (op_r == bhf_pkg::OP_FILL) begin
          if (is_under) begin
            status_r <= bhf_pkg::STAT_UNDERFLOW;
          end else if (is_over) begin
            status_r <= bhf_pkg::STAT_OVERFLOW;
          end
        end
      end
      bhf_pkg::ST_DIV: begin
        if (!div_busy) addr_r <= quotient;
      end
      bhf_pkg::ST_UPD: begin
        idx_r <= bhf_pkg::IDX_OUT_W'(addr_r);
        if (op_r == bhf_pkg::OP_READ) begin
          status_r <= bhf_pkg::STAT_READ_OK;
          val_r    <= rd_count;
        end else begin
          status_r <= bhf_pkg::STAT_BINNED;
          val_r    <= inc_count;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Running totals, all saturating
  // ---------------------------------------------------------------------------
  logic signed [bhf_pkg::SUM_W:0]   sum_wide;
  logic [bhf_pkg::SUM_W-1:0]        sum_sat;
  logic [bhf_pkg::SQSUM_W:0]        sqsum_wide;
  logic [bhf_pkg::SQSUM_W-1:0]      sqsum_sat;

  assign sum_wide = (bhf_pkg::SUM_W+1)'(sum_r) + (bhf_pkg::SUM_W+1)'(sample_r);

  always_comb begin
    if (sum_wide[bhf_pkg::SUM_W] != sum_wide[bhf_pkg::SUM_W-1]) begin
      // Clamp to the limit on the side of the true sign
      sum_sat = {sum_wide[bhf_pkg::SUM_W], {(bhf_pkg::SUM_W-1){!sum_wide[bhf_pkg::SUM_W]}}};
    end else begin
      sum_sat = sum_wide[bhf_pkg::SUM_W-1:0];
    end
  end

  assign sqsum_wide = {1'b0, sqsum_r} + (bhf_pkg::SQSUM_W+1)'(sq_r);
  assign sqsum_sat  = sqsum_wide[bhf_pkg::SQSUM_W] ? '1 : sqsum_wide[bhf_pkg::SQSUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      below_r <= '0;
      above_r <= '0;
      sum_r   <= '0;
      sqsum_r <= '0;
    end else begin
      if (state_r == bhf_pkg::ST_EVAL && op_r == bhf_pkg::OP_FILL) begin
        if (is_under && !(&below_r)) below_r <= below_r + COUNT_BITS'(1);
        if (is_over && !(&above_r))  above_r <= above_r + COUNT_BITS'(1);
      end
      if (store_ctrl.inc_en) begin
        if (!(&entry_r)) entry_r <= entry_r + COUNT_BITS'(1);
        sum_r   <= sum_sat;
        sqsum_r <= sqsum_sat;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: hold the result until taken, load the next when free
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= status_r;
      out_idx_r     <= idx_r;
      out_val_r     <= bhf_pkg::CNT_OUT_W'(val_r);
      out_entries_r <= bhf_pkg::CNT_OUT_W'(entry_r);
      out_under_r   <= bhf_pkg::CNT_OUT_W'(below_r);
      out_over_r    <= bhf_pkg::CNT_OUT_W'(above_r);
      out_sum_r     <= sum_r;
      out_sqsum_r   <= sqsum_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_sqsum_r, out_sum_r, out_over_r, out_under_r,
                       out_entries_r, out_val_r, out_idx_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    store_clearing |-> !in_tready)
    else $error("item accepted during bin clearing sweep");

  a_binned_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == bhf_pkg::STAT_BINNED) |-> (out_tdata[39:8] != '0))
    else $error("binned result with zero bin count");

  a_unbinned_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == bhf_pkg::STAT_UNDERFLOW ||
                    out_tuser == bhf_pkg::STAT_OVERFLOW ||
                    out_tuser == bhf_pkg::STAT_READ_BAD))
    |-> (out_tdata[39:0] == '0))
    else $error("unbinned result carries a bin index or count");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_inc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    store_ctrl.inc_en |-> $past(store_ctrl.rd_en))
    else $error("bin written back without a read the cycle before");

endmodule

FILE: rtl/bhf_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on bhf_pkg (remainder width).
module bhf_div #(
  parameter int DVD_W = 29,
  parameter int QW    = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DVD_W-1:0]            dividend,
  input  logic [bhf_pkg::OFF_W-1:0]   divisor,
  output logic                        busy,
  output logic [QW-1:0]               quotient
);

  localparam int CNT_W = $clog2(QW + 1);

  logic                      busy_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [bhf_pkg::OFF_W-1:0] rem_r;
  logic [bhf_pkg::OFF_W-1:0] dvs_r;
  logic [QW-1:0]             dq_r;
  logic [bhf_pkg::OFF_W:0]   trial;
  logic                      qbit;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_r, dq_r[QW-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(QW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Quotient is known to fit QW bits, so the upper dividend part is below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[QW +: bhf_pkg::OFF_W];
      dq_r  <= dividend[QW-1:0];
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= qbit ? bhf_pkg::OFF_W'(trial - {1'b0, dvs_r}) : trial[bhf_pkg::OFF_W-1:0];
      dq_r  <= QW'({dq_r, qbit});
    end
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule

FILE: rtl/bhf_bin_store.sv
// Bin counter memory with a clearing sweep after reset and a saturating increment.
// Depends on bhf_pkg (store control struct).
module bhf_bin_store #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bhf_pkg::bhf_store_ctrl_t       ctrl,
  input  logic [$clog2(MAX_BINS)-1:0]    addr,
  output logic                           clearing,
  output logic [COUNT_BITS-1:0]          rd_count,
  output logic [COUNT_BITS-1:0]          inc_count
);

  localparam int AW = $clog2(MAX_BINS);

  logic [COUNT_BITS-1:0] mem [MAX_BINS];
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  clr_busy_r;
  logic [AW-1:0]         clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(MAX_BINS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Write zeros during the sweep, else write back the incremented count
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (ctrl.inc_en) begin
      mem[addr] <= inc_count;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign inc_count = (&rd_data_r) ? rd_data_r : rd_data_r + COUNT_BITS'(1);
  assign rd_count  = rd_data_r;
  assign clearing  = clr_busy_r;

endmodule

FILE: tb/binned_histogram_fill_test.sv
`timescale 1ns / 100ps
// Self-checking bench for binned_histogram_fill: directed range and bin-count corners, then
// random fills and bin reads over many range settings, checked against an in-bench histogram.
// Depends on bhf_pkg and the binned_histogram_fill RTL only.
module binned_histogram_fill_test;

  localparam int          MAX_BINS = 256;
  localparam logic [31:0] CNT_CAP  = '1;
  localparam longint      SUM_HI   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      SUM_LO   = -64'sh0000_8000_0000_0000;
  localparam longint      SQ_CAP   = 64'sh7FFF_FFFF_FFFF_FFFF;

  // One result item, field by field
  typedef struct packed {
    logic [bhf_pkg::STATUS_W-1:0] status;
    logic [7:0]                   bin_index;
    logic [31:0]                  bin_value;
    logic [31:0]                  entries;
    logic [31:0]                  underflows;
    logic [31:0]                  overflows;
    logic [47:0]                  value_sum;
    logic [62:0]                  square_sum;
  } hist_result_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_COIN,
    RX_EVERY_FOURTH,
    RX_RARE_STALL
  } rx_pattern_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [bhf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bhf_pkg::CFG_W-1:0]     cfg_data;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [23:0]                   in_tdata;   // [15:0] sample, [23:16] bin_select
  logic                          in_tuser;   // [0] op
  logic                          out_tvalid;
  logic                          out_tready;
  logic [247:0]                  out_tdata;  // [7:0] bin_index, [39:8] bin_value,
                                             // [71:40] entries, [103:72] underflow_count,
                                             // [135:104] overflow_count, [183:136] value_sum,
                                             // [246:184] square_sum, [247] zero
  logic [bhf_pkg::STATUS_W-1:0]  out_tuser;  // [2:0] status

  // Histogram state as the block should hold it
  int          edge_lo;
  int          edge_hi;
  int unsigned bins_cfg;
  logic [31:0] bin_counts [MAX_BINS];
  logic [31:0] entry_cnt;
  logic [31:0] under_cnt;
  logic [31:0] over_cnt;
  longint      sum_acc;
  longint      sq_acc;

  hist_result_t expected_q[$];
  int errors;
  int results_seen;
  int burst_left;
  int hold_cycles;

  binned_histogram_fill uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ------------------------------------------------------------------
  // Histogram prediction
  // ------------------------------------------------------------------

  // Zero bins acts as one bin; anything above MAX_BINS is clamped
  function automatic int bins_in_use();
    if (bins_cfg == 0) return 1;
    if (bins_cfg > MAX_BINS) return MAX_BINS;
    return bins_cfg;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == CNT_CAP) ? c : c + 32'd1;
  endfunction

  task automatic clear_histogram();
    edge_lo   = -32768;
    edge_hi   = 32767;
    bins_cfg  = 256;
    entry_cnt = '0;
    under_cnt = '0;
    over_cnt  = '0;
    sum_acc   = 0;
    sq_acc    = 0;
    for (int i = 0; i < MAX_BINS; i++) bin_counts[i] = '0;
  endtask

  // Apply one accepted item to the histogram and return the result it must produce
  function automatic hist_result_t histogram_step(logic op, logic [15:0] smp, logic [7:0] sel);
    hist_result_t r;
    int           v;
    int           nb;
    int           bin;
    longint       sq;
    v  = int'($signed(smp));
    nb = bins_in_use();
    r  = '0;
    if (op == bhf_pkg::OP_READ) begin
      if (int'(sel) < nb) begin
        r.status    = bhf_pkg::STAT_READ_OK;
        r.bin_index = sel;
        r.bin_value = bin_counts[sel];
      end else begin
        r.status = bhf_pkg::STAT_READ_BAD;
      end
    end else if (v < edge_lo) begin
      r.status  = bhf_pkg::STAT_UNDERFLOW;
      under_cnt = bump(under_cnt);
    end else if (v >= edge_hi) begin
      // also covers the empty range, where nothing can be binned
      r.status = bhf_pkg::STAT_OVERFLOW;
      over_cnt = bump(over_cnt);
    end else begin
      bin = ((v - edge_lo) * nb) / (edge_hi - edge_lo);
      if (bin >= nb) bin = nb - 1;
      bin_counts[bin] = bump(bin_counts[bin]);
      entry_cnt       = bump(entry_cnt);
      sum_acc         = sum_acc + longint'(v);
      if (sum_acc > SUM_HI) sum_acc = SUM_HI;
      else if (sum_acc < SUM_LO) sum_acc = SUM_LO;
      sq     = longint'(v) * longint'(v);
      sq_acc = (sq_acc > SQ_CAP - sq) ? SQ_CAP : sq_acc + sq;
      r.status    = bhf_pkg::STAT_BINNED;
      r.bin_index = bin[7:0];
      r.bin_value = bin_counts[bin];
    end
    r.entries    = entry_cnt;
    r.underflows = under_cnt;
    r.overflows  = over_cnt;
    r.value_sum  = sum_acc[47:0];
    r.square_sum = sq_acc[62:0];
    return r;
  endfunction

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    errors++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                results_seen, name, got, want));
  endtask

  // Compare every accepted result with the oldest expectation
  initial begin
    hist_result_t got;
    hist_result_t want;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.status     = out_tuser;
        got.bin_index  = out_tdata[7:0];
        got.bin_value  = out_tdata[39:8];
        got.entries    = out_tdata[71:40];
        got.underflows = out_tdata[103:72];
        got.overflows  = out_tdata[135:104];
        got.value_sum  = out_tdata[183:136];
        got.square_sum = out_tdata[246:184];
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
          want = expected_q.pop_front();
          check_field("status", 64'(got.status), 64'(want.status));
          check_field("bin_index", 64'(got.bin_index), 64'(want.bin_index));
          check_field("bin_value", 64'(got.bin_value), 64'(want.bin_value));
          check_field("entries", 64'(got.entries), 64'(want.entries));
          check_field("underflow_count", 64'(got.underflows), 64'(want.underflows));
          check_field("overflow_count", 64'(got.overflows), 64'(want.overflows));
          check_field("value_sum", 64'(got.value_sum), 64'(want.value_sum));
          check_field("square_sum", 64'(got.square_sum), 64'(want.square_sum));
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver: switch between stall patterns, or hold off entirely while
  // hold_cycles is nonzero so the block backs up into its input
  // ------------------------------------------------------------------
  initial begin
    rx_pattern_t pattern;
    int          pattern_left;
    int          tick;
    pattern      = RX_STEADY;
    pattern_left = 0;
    tick         = 0;
    out_tready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        if (pattern_left == 0) begin
          pattern      = rx_pattern_t'($urandom_range(0, 3));
          pattern_left = $urandom_range(32, 200);
        end
        pattern_left--;
        tick++;
        case (pattern)
          RX_STEADY:       out_tready <= 1'b1;
          RX_COIN:         out_tready <= 1'($urandom_range(0, 1));
          RX_EVERY_FOURTH: out_tready <= (tick % 4 == 0);
          default:         out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ------------------------------------------------------------------
  // Sender and configuration
  // ------------------------------------------------------------------

  // Offer one item; between bursts drop valid for a random gap.
  // The expectation is recorded at the edge the item is accepted.
  task automatic send_item(logic op, int sample, int sel);
    logic [15:0] smp;
    logic [7:0]  s8;
    int          gap;
    smp = sample[15:0];
    s8  = sel[7:0];
    if (burst_left == 0) begin
      gap = $urandom_range(0, 15);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {s8, smp};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(histogram_step(op, smp, s8));
    burst_left--;
  endtask

  // Stop offering items and hold until every expected result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(posedge clk);
    // let the block settle back to idle
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [bhf_pkg::CFG_IDX_W-1:0] idx, int value);
    logic [15:0] d;
    d = value[15:0];
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bhf_pkg::REG_LOW_EDGE:  edge_lo = int'($signed(d));
      bhf_pkg::REG_HIGH_EDGE: edge_hi = int'($signed(d));
      bhf_pkg::REG_BIN_COUNT: bins_cfg = 32'(d[8:0]);
      default: ;
    endcase
  endtask

  // Change the range only once the block has drained
  task automatic set_range(int lo, int hi, int nbins);
    wait_for_results();
    write_register(bhf_pkg::REG_LOW_EDGE, lo);
    write_register(bhf_pkg::REG_HIGH_EDGE, hi);
    write_register(bhf_pkg::REG_BIN_COUNT, nbins);
  endtask

  // One random item: mostly fills aimed inside the range, some at its edges,
  // some anywhere; reads mostly hit a bin in use
  task automatic random_item();
    int nb;
    int sel;
    int sample;
    int pick;
    nb = bins_in_use();
    if ($urandom_range(0, 4) == 0) begin
      sel = ($urandom_range(0, 3) != 0) ? $urandom_range(0, nb - 1) : $urandom_range(0, 255);
      send_item(bhf_pkg::OP_READ, $urandom, sel);
    end else begin
      pick = $urandom_range(0, 9);
      if (pick <= 5 && edge_hi > edge_lo)
        sample = edge_lo + int'($urandom_range(0, edge_hi - edge_lo - 1));
      else if (pick <= 6)
        case ($urandom_range(0, 3))
          0:       sample = edge_lo - 1;
          1:       sample = edge_lo;
          2:       sample = edge_hi - 1;
          default: sample = edge_hi;
        endcase
      else
        sample = $urandom_range(0, 65535);
      send_item(bhf_pkg::OP_FILL, sample, $urandom);
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Reset range is the full sample range at 256 bins
  task automatic test_reset_state();
    send_item(bhf_pkg::OP_READ, $urandom, 0);
    send_item(bhf_pkg::OP_READ, $urandom, 255);
    send_item(bhf_pkg::OP_FILL, -32768, $urandom);  // lowest sample, first bin
    send_item(bhf_pkg::OP_FILL, 32766, $urandom);   // last bin
    send_item(bhf_pkg::OP_FILL, 32767, $urandom);   // high edge is exclusive
    wait_for_results();
  endtask

  task automatic test_range_edges();
    set_range(-100, 100, 10);
    send_item(bhf_pkg::OP_FILL, -101, $urandom);    // just below: underflow
    send_item(bhf_pkg::OP_FILL, -100, $urandom);
    send_item(bhf_pkg::OP_FILL, 99, $urandom);
    send_item(bhf_pkg::OP_FILL, 100, $urandom);     // at high edge: overflow
    // same bin back to back, then read it right away
    send_item(bhf_pkg::OP_FILL, 0, $urandom);
    send_item(bhf_pkg::OP_FILL, 0, $urandom);
    send_item(bhf_pkg::OP_READ, $urandom, 5);
    send_item(bhf_pkg::OP_READ, $urandom, 10);      // one past the last bin
    wait_for_results();
  endtask

  task automatic test_bin_count_limits();
    // zero bins behaves as a single bin
    set_range(-1000, 1000, 0);
    send_item(bhf_pkg::OP_FILL, 999, $urandom);
    send_item(bhf_pkg::OP_READ, $urandom, 0);
    send_item(bhf_pkg::OP_READ, $urandom, 1);
    // above the maximum clamps to 256 bins
    set_range(-1000, 1000, 511);
    send_item(bhf_pkg::OP_FILL, 999, $urandom);
    send_item(bhf_pkg::OP_READ, $urandom, 255);
    wait_for_results();
  endtask

  task automatic test_empty_range();
    set_range(50, 50, 16);
    send_item(bhf_pkg::OP_FILL, 49, $urandom);
    send_item(bhf_pkg::OP_FILL, 50, $urandom);
    // inverted edges: nothing is ever binned
    set_range(32767, -32768, 256);
    send_item(bhf_pkg::OP_FILL, 0, $urandom);
    send_item(bhf_pkg::OP_FILL, 32767, $urandom);
    wait_for_results();
  endtask

  task automatic test_random_settings();
    int lo;
    int span_max;
    int nbins;
    int pick;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: set_range(-32768, 32767, 256);
        1: set_range(-32768, -32767, 1);
        2: set_range(32766, 32767, 511);
        3: set_range(0, 3, 256);        // more bins than values
        default: begin
          pick     = $urandom_range(0, 7);
          lo       = int'($urandom_range(0, 65534)) - 32768;
          span_max = 32767 - lo;
          if (pick < 4 && span_max > 400) span_max = 400;
          case ($urandom_range(0, 15))
            0:       nbins = 0;
            1:       nbins = $urandom_range(257, 511);
            2, 3, 4: nbins = $urandom_range(1, 8);
            default: nbins = $urandom_range(1, 256);
          endcase
          if (pick == 0)
            set_range(lo, int'($urandom_range(0, lo + 32768)) - 32768, nbins);
          else
            set_range(lo, lo + int'($urandom_range(1, span_max)), nbins);
        end
      endcase
      repeat (150) random_item();
    end
    wait_for_results();
  endtask

  // Hold the receiver off while items keep coming, so the block stalls its input
  task automatic test_output_stall();
    set_range(-8, 8, 4);
    hold_cycles = 300;
    repeat (40) random_item();
    wait_for_results();
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = bhf_pkg::REG_LOW_EDGE;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = bhf_pkg::OP_FILL;
    errors       = 0;
    results_seen = 0;
    burst_left   = 0;
    hold_cycles  = 0;
    clear_histogram();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // the bin clearing sweep after reset keeps in_tready low; send_item waits it out
    test_reset_state();
    test_range_edges();
    test_bin_count_limits();
    test_empty_range();
    test_random_settings();
    test_output_stall();

    wait_for_results();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
